[hdl/ffs_pkg.sv]
// Shared types, register indexes, command codes and reset values of the failsafe supervisor.
`default_nettype none

package ffs_pkg;

   // Flight mode codes. Code 3 is never produced.
   typedef enum logic [1:0] {
      MODE_MANUAL  = 2'd0,
      MODE_CLIMB   = 2'd1,
      MODE_LANDING = 2'd2
   } mode_type;

   // Arm command codes. The fourth code is reserved and ignored.
   localparam logic [1:0] ARM_CMD_NONE   = 2'd0;
   localparam logic [1:0] ARM_CMD_ARM    = 2'd1;
   localparam logic [1:0] ARM_CMD_DISARM = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILT_LIMIT       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RC_TIMEOUT_MS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAND_TIME_MS     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAKEOFF_THROTTLE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STANDBY_THROTTLE = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [10:0] TILT_LIMIT_RST       = 11'd800;
   localparam logic [15:0] RC_TIMEOUT_MS_RST    = 16'd1000;
   localparam logic [15:0] LAND_TIME_MS_RST     = 16'd4000;
   localparam logic [9:0]  TAKEOFF_THROTTLE_RST = 10'd600;
   localparam logic [9:0]  STANDBY_THROTTLE_RST = 10'd200;

endpackage : ffs_pkg

`default_nettype wire

[hdl/flight_failsafe_supervisor_unit.sv]
// Top level of the flight failsafe supervisor: arming, tilt and radio failsafe, mode machine.
//
// Usage: one request beat on the req_ channel is one control-loop tick. It carries the time
// stamps, attitude, pilot throttle, altitude and an arm command. For every request beat the
// block returns exactly one response beat on the rsp_ channel, in order, with the flight mode,
// arming state, failsafe pulses, the throttle after standby override and the takeoff altitude.
// Both channels use valid/ready; the csr_ channel writes the five configuration registers and
// is always ready. The user must write registers only while no tick is in flight; the block
// itself does not enforce this. A request beat is held in the input register, evaluated in
// one pass of short logic and moved into the result register, once free, as a response beat.
// Throughput: one beat per cycle while rsp_ready is high. The input and result registers
// part the two sides, so a new request is taken while a finished response waits to be taken.
// Stall: when rsp_ready is low the response holds, the tick in the input register waits and
// req_ready drops once both registers are full; nothing is lost or repeated.
// Reset (synchronous, active high): configuration returns to its default values, the craft is
// disarmed, on the ground, in manual mode, with radio not lost and no landing timer running.
`default_nettype none

module flight_failsafe_supervisor_unit
   import ffs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [31:0]            req_now_ms,
   input  wire logic [31:0]            req_last_radio_ms,
   input  wire logic signed [11:0]     req_pitch_tenths,
   input  wire logic signed [11:0]     req_roll_tenths,
   input  wire logic [9:0]             req_throttle_in,
   input  wire logic signed [31:0]     req_altitude_z,
   input  wire logic [1:0]             req_arm_command,
   // Response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_flight_mode,
   output logic                        rsp_motors_armed,
   output logic                        rsp_motor_kill,
   output logic                        rsp_radio_lost,
   output logic                        rsp_airborne,
   output logic                        rsp_integrator_reset,
   output logic                        rsp_head_free_request,
   output logic [9:0]                  rsp_throttle_out,
   output logic signed [31:0]          rsp_takeoff_altitude,
   // Configuration write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers
   logic [10:0] tilt_limit_ff;
   logic [15:0] rc_timeout_ms_ff;
   logic [15:0] land_time_ms_ff;
   logic [9:0]  takeoff_throttle_ff;
   logic [9:0]  standby_throttle_ff;

   // Input register
   logic               in_valid_ff;
   logic [31:0]        now_ms_ff;
   logic [31:0]        last_radio_ms_ff;
   logic signed [11:0] pitch_ff;
   logic signed [11:0] roll_ff;
   logic [9:0]         throttle_ff;
   logic signed [31:0] altitude_ff;
   logic [1:0]         arm_cmd_ff;

   // Supervisor state
   mode_type           mode_ff,       mode_in;
   logic               armed_ff,      armed_in;
   logic               airborne_ff,   airborne_in;
   logic               radio_lost_ff, radio_lost_in;
   logic               timer_valid_ff, timer_valid_in;
   logic [31:0]        land_start_ff, land_start_in;
   logic signed [31:0] takeoff_alt_ff, takeoff_alt_in;

   // Result register (pulses and throttle; the rest is read from the state)
   logic       out_valid_ff;
   logic       kill_ff,      kill_in;
   logic       int_reset_ff, int_reset_in;
   logic       head_free_ff, head_free_in;
   logic [9:0] thr_out_ff,   thr_out_in;

   // Per-tick intermediate values
   logic        advance;
   logic        armed_cmd;
   logic [11:0] abs_pitch;
   logic [11:0] abs_roll;
   logic        tilt_kill;
   logic        armed_tilt;
   logic [15:0] silence;
   logic        lost;
   mode_type    mode_lost;
   logic        takeoff_hit;
   logic        standby_hit;
   logic        landing_run;
   logic [31:0] land_start_eff;
   logic [31:0] land_elapsed;

   // The tick in the input register moves on when the result register is free or being taken.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Stage one: arm or disarm command; the reserved code leaves the flag alone.
   always_comb begin
      case (arm_cmd_ff)
         ARM_CMD_ARM:    armed_cmd = 1'b1;
         ARM_CMD_DISARM: armed_cmd = 1'b0;
         default:        armed_cmd = armed_ff;
      endcase
   end

   // Stage two: tilt failsafe. A 12-bit magnitude holds 2048, the magnitude of the most
   // negative code, so no extra bit is needed.
   assign abs_pitch  = pitch_ff[11] ? (12'd0 - 12'(pitch_ff)) : 12'(pitch_ff);
   assign abs_roll   = roll_ff[11]  ? (12'd0 - 12'(roll_ff))  : 12'(roll_ff);
   assign tilt_kill  = (abs_pitch > {1'b0, tilt_limit_ff}) || (abs_roll > {1'b0, tilt_limit_ff});
   assign armed_tilt = armed_cmd && !tilt_kill;

   // Radio failsafe: silence is taken modulo 65536 ms.
   assign silence   = now_ms_ff[15:0] - last_radio_ms_ff[15:0];
   assign lost      = silence > rc_timeout_ms_ff;
   assign mode_lost = (lost && (airborne_ff || armed_tilt)) ? MODE_LANDING : mode_ff;

   // Stage three: mode machine while armed.
   assign takeoff_hit = armed_tilt && (throttle_ff >= takeoff_throttle_ff)
                        && (mode_lost != MODE_CLIMB);
   assign standby_hit = armed_tilt && (throttle_ff < takeoff_throttle_ff)
                        && (mode_lost == MODE_MANUAL);

   // Stage four: landing sequencer. A timer that is not running starts at this tick.
   assign landing_run    = (mode_lost == MODE_LANDING) && !takeoff_hit;
   assign land_start_eff = timer_valid_ff ? land_start_ff : now_ms_ff;
   assign land_elapsed   = now_ms_ff - land_start_eff;

   // Next state
   always_comb begin
      mode_in        = mode_lost;
      armed_in       = armed_tilt;
      airborne_in    = airborne_ff;
      radio_lost_in  = lost;
      timer_valid_in = timer_valid_ff;
      land_start_in  = land_start_ff;
      takeoff_alt_in = takeoff_alt_ff;
      if (takeoff_hit) begin
         mode_in        = MODE_CLIMB;
         airborne_in    = 1'b1;
         takeoff_alt_in = 32'sd0 - altitude_ff;
      end
      if (landing_run) begin
         if (airborne_ff) begin
            land_start_in  = land_start_eff;
            timer_valid_in = 1'b1;
            if (land_elapsed > {16'd0, land_time_ms_ff}) begin
               mode_in        = MODE_MANUAL;
               armed_in       = 1'b0;
               airborne_in    = 1'b0;
               timer_valid_in = 1'b0;
            end
         end else begin
            // On the ground: landing is over at once.
            mode_in  = MODE_MANUAL;
            armed_in = 1'b0;
         end
      end
   end

   // Result values
   always_comb begin
      kill_in      = tilt_kill;
      int_reset_in = takeoff_hit;
      head_free_in = takeoff_hit;
      thr_out_in   = standby_hit ? standby_throttle_ff : throttle_ff;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_limit_ff       <= TILT_LIMIT_RST;
         rc_timeout_ms_ff    <= RC_TIMEOUT_MS_RST;
         land_time_ms_ff     <= LAND_TIME_MS_RST;
         takeoff_throttle_ff <= TAKEOFF_THROTTLE_RST;
         standby_throttle_ff <= STANDBY_THROTTLE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TILT_LIMIT:       tilt_limit_ff       <= csr_wdata[10:0];
            CSR_RC_TIMEOUT_MS:    rc_timeout_ms_ff    <= csr_wdata;
            CSR_LAND_TIME_MS:     land_time_ms_ff     <= csr_wdata;
            CSR_TAKEOFF_THROTTLE: takeoff_throttle_ff <= csr_wdata[9:0];
            CSR_STANDBY_THROTTLE: standby_throttle_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         now_ms_ff        <= req_now_ms;
         last_radio_ms_ff <= req_last_radio_ms;
         pitch_ff         <= req_pitch_tenths;
         roll_ff          <= req_roll_tenths;
         throttle_ff      <= req_throttle_in;
         altitude_ff      <= req_altitude_z;
         arm_cmd_ff       <= req_arm_command;
      end
   end

   // State and result register advance together, so the state registers hold exactly the
   // values of the response on display.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_MANUAL;
         armed_ff       <= 1'b0;
         airborne_ff    <= 1'b0;
         radio_lost_ff  <= 1'b0;
         timer_valid_ff <= 1'b0;
         takeoff_alt_ff <= 32'sd0;
      end else if (advance) begin
         mode_ff        <= mode_in;
         armed_ff       <= armed_in;
         airborne_ff    <= airborne_in;
         radio_lost_ff  <= radio_lost_in;
         timer_valid_ff <= timer_valid_in;
         takeoff_alt_ff <= takeoff_alt_in;
      end
   end

   // The timer start is only read while its valid bit is set.
   always_ff @(posedge clock) begin
      if (advance) begin
         land_start_ff <= land_start_in;
         kill_ff       <= kill_in;
         int_reset_ff  <= int_reset_in;
         head_free_ff  <= head_free_in;
         thr_out_ff    <= thr_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_flight_mode       = mode_ff;
   assign rsp_motors_armed      = armed_ff;
   assign rsp_motor_kill        = kill_ff;
   assign rsp_radio_lost        = radio_lost_ff;
   assign rsp_airborne          = airborne_ff;
   assign rsp_integrator_reset  = int_reset_ff;
   assign rsp_head_free_request = head_free_ff;
   assign rsp_throttle_out      = thr_out_ff;
   assign rsp_takeoff_altitude  = takeoff_alt_ff;

endmodule : flight_failsafe_supervisor_unit

`default_nettype wire

[hdl/ffs_checker.sv]
// Port-level checker of the failsafe supervisor and its bind to the top level.
`default_nettype none

module ffs_checker
   import ffs_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic [31:0]            req_now_ms,
   input wire logic [31:0]            req_last_radio_ms,
   input wire logic signed [11:0]     req_pitch_tenths,
   input wire logic signed [11:0]     req_roll_tenths,
   input wire logic [9:0]             req_throttle_in,
   input wire logic signed [31:0]     req_altitude_z,
   input wire logic [1:0]             req_arm_command,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [1:0]             rsp_flight_mode,
   input wire logic                   rsp_motors_armed,
   input wire logic                   rsp_motor_kill,
   input wire logic                   rsp_radio_lost,
   input wire logic                   rsp_airborne,
   input wire logic                   rsp_integrator_reset,
   input wire logic                   rsp_head_free_request,
   input wire logic [9:0]             rsp_throttle_out,
   input wire logic signed [31:0]     rsp_takeoff_altitude,
   input wire logic                   csr_valid,
   input wire logic                   csr_ready,
   input wire logic [CSR_INDEX_W-1:0] csr_index,
   input wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // A stalled response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_flight_mode)
         && $stable(rsp_motors_armed) && $stable(rsp_throttle_out)
         && $stable(rsp_takeoff_altitude))
      else $error("response beat changed while stalled");

   // A tilt kill always leaves the craft disarmed.
   a_kill_disarms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motor_kill |-> !rsp_motors_armed)
      else $error("motor kill with motors still armed");

   // The takeoff pulses come together with an armed, airborne climb.
   a_takeoff: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_head_free_request |-> rsp_integrator_reset && rsp_airborne
         && rsp_motors_armed && (rsp_flight_mode == MODE_CLIMB))
      else $error("takeoff pulse without armed climb");

   // Landing only remains in effect while airborne.
   a_landing_airborne: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_flight_mode == MODE_LANDING) |-> rsp_airborne)
      else $error("landing mode reported on the ground");

endmodule : ffs_checker

bind flight_failsafe_supervisor_unit ffs_checker u_ffs_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .req_now_ms            (req_now_ms),
   .req_last_radio_ms     (req_last_radio_ms),
   .req_pitch_tenths      (req_pitch_tenths),
   .req_roll_tenths       (req_roll_tenths),
   .req_throttle_in       (req_throttle_in),
   .req_altitude_z        (req_altitude_z),
   .req_arm_command       (req_arm_command),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_flight_mode       (rsp_flight_mode),
   .rsp_motors_armed      (rsp_motors_armed),
   .rsp_motor_kill        (rsp_motor_kill),
   .rsp_radio_lost        (rsp_radio_lost),
   .rsp_airborne          (rsp_airborne),
   .rsp_integrator_reset  (rsp_integrator_reset),
   .rsp_head_free_request (rsp_head_free_request),
   .rsp_throttle_out      (rsp_throttle_out),
   .rsp_takeoff_altitude  (rsp_takeoff_altitude),
   .csr_valid             (csr_valid),
   .csr_ready             (csr_ready),
   .csr_index             (csr_index),
   .csr_wdata             (csr_wdata)
);

`default_nettype wire

[tb/flight_failsafe_supervisor_checker.sv]
// Checker for the flight failsafe supervisor: predicts each response beat and compares it.
module flight_failsafe_supervisor_checker
   import ffs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire logic [31:0]            req_now_ms,
   input  wire logic [31:0]            req_last_radio_ms,
   input  wire logic signed [11:0]     req_pitch_tenths,
   input  wire logic signed [11:0]     req_roll_tenths,
   input  wire logic [9:0]             req_throttle_in,
   input  wire logic signed [31:0]     req_altitude_z,
   input  wire logic [1:0]             req_arm_command,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire logic [1:0]             rsp_flight_mode,
   input  wire logic                   rsp_motors_armed,
   input  wire logic                   rsp_motor_kill,
   input  wire logic                   rsp_radio_lost,
   input  wire logic                   rsp_airborne,
   input  wire logic                   rsp_integrator_reset,
   input  wire logic                   rsp_head_free_request,
   input  wire logic [9:0]             rsp_throttle_out,
   input  wire logic signed [31:0]     rsp_takeoff_altitude,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          status_backlog_size,
   output int                          mismatch_count
);

   typedef struct packed {
      mode_type    flight_mode;
      logic        motors_armed;
      logic        motor_kill;
      logic        radio_lost;
      logic        airborne;
      logic        integrator_reset;
      logic        head_free_request;
      logic [9:0]  throttle_out;
      logic [31:0] takeoff_altitude;
   } supervisor_status_type;

   // Shadow of the configuration registers.
   logic [10:0] tilt_limit_q;
   logic [15:0] rc_timeout_q;
   logic [15:0] land_time_q;
   logic [9:0]  takeoff_thr_q;
   logic [9:0]  standby_thr_q;

   // Shadow of the supervisor state.
   mode_type    fsm_mode;
   logic        armed_q;
   logic        airborne_q;
   logic        link_lost_q;
   logic        land_timer_run;
   logic [31:0] land_start_ms;
   logic [31:0] takeoff_alt_q;

   supervisor_status_type status_backlog[$];
   supervisor_status_type due_status;

   function automatic logic [12:0] tilt_magnitude(input logic [11:0] angle);
      return angle[11] ? 13'h1000 - {1'b0, angle} : {1'b0, angle};
   endfunction

   // One control tick: arm command, failsafe, mode machine, then the landing sequencer.
   function automatic supervisor_status_type supervise_tick(
         input logic [31:0] now, input logic [31:0] last,
         input logic [11:0] pitch, input logic [11:0] roll,
         input logic [9:0] thr, input logic [31:0] z, input logic [1:0] cmd);
      supervisor_status_type st;
      logic [15:0]           silence;
      st = '0;
      st.throttle_out = thr;
      if (cmd == ARM_CMD_ARM) begin
         armed_q = 1'b1;
      end else if (cmd == ARM_CMD_DISARM) begin
         armed_q = 1'b0;
      end
      if (tilt_magnitude(pitch) > {2'b00, tilt_limit_q} ||
          tilt_magnitude(roll) > {2'b00, tilt_limit_q}) begin
         st.motor_kill = 1'b1;
         armed_q = 1'b0;
      end
      silence = now[15:0] - last[15:0];
      if (silence > rc_timeout_q) begin
         if (airborne_q || armed_q) begin
            fsm_mode = MODE_LANDING;
         end
         link_lost_q = 1'b1;
      end else begin
         link_lost_q = 1'b0;
      end
      if (armed_q) begin
         if (thr >= takeoff_thr_q) begin
            if (fsm_mode != MODE_CLIMB) begin
               st.integrator_reset  = 1'b1;
               st.head_free_request = 1'b1;
               fsm_mode      = MODE_CLIMB;
               airborne_q    = 1'b1;
               takeoff_alt_q = 32'd0 - z;
            end
         end else if (fsm_mode == MODE_MANUAL) begin
            st.throttle_out = standby_thr_q;
         end
      end
      if (fsm_mode == MODE_LANDING) begin
         if (airborne_q) begin
            if (!land_timer_run) begin
               land_start_ms  = now;
               land_timer_run = 1'b1;
            end
            if (now - land_start_ms > {16'd0, land_time_q}) begin
               fsm_mode       = MODE_MANUAL;
               armed_q        = 1'b0;
               airborne_q     = 1'b0;
               land_timer_run = 1'b0;
            end
         end else begin
            fsm_mode = MODE_MANUAL;
            armed_q  = 1'b0;
         end
      end
      st.flight_mode      = fsm_mode;
      st.motors_armed     = armed_q;
      st.radio_lost       = link_lost_q;
      st.airborne         = airborne_q;
      st.takeoff_altitude = takeoff_alt_q;
      return st;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: rsp_%s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tilt_limit_q   = TILT_LIMIT_RST;
         rc_timeout_q   = RC_TIMEOUT_MS_RST;
         land_time_q    = LAND_TIME_MS_RST;
         takeoff_thr_q  = TAKEOFF_THROTTLE_RST;
         standby_thr_q  = STANDBY_THROTTLE_RST;
         fsm_mode       = MODE_MANUAL;
         armed_q        = 1'b0;
         airborne_q     = 1'b0;
         link_lost_q    = 1'b0;
         land_timer_run = 1'b0;
         land_start_ms  = '0;
         takeoff_alt_q  = '0;
         status_backlog.delete();
         mismatch_count = 0;
         status_backlog_size <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TILT_LIMIT:       tilt_limit_q  = csr_wdata[10:0];
               CSR_RC_TIMEOUT_MS:    rc_timeout_q  = csr_wdata;
               CSR_LAND_TIME_MS:     land_time_q   = csr_wdata;
               CSR_TAKEOFF_THROTTLE: takeoff_thr_q = csr_wdata[9:0];
               CSR_STANDBY_THROTTLE: standby_thr_q = csr_wdata[9:0];
               default: ;
            endcase
         end
         // A response beat belongs to an earlier request, so it is matched first.
         if (rsp_valid && rsp_ready) begin
            if (status_backlog.size() == 0) begin
               $display("%0t: response beat with nothing outstanding, expected none, actual mode %0h",
                        $time, rsp_flight_mode);
               mismatch_count++;
            end else begin
               due_status = status_backlog.pop_front();
               check_field("flight_mode", due_status.flight_mode, rsp_flight_mode);
               check_field("motors_armed", due_status.motors_armed, rsp_motors_armed);
               check_field("motor_kill", due_status.motor_kill, rsp_motor_kill);
               check_field("radio_lost", due_status.radio_lost, rsp_radio_lost);
               check_field("airborne", due_status.airborne, rsp_airborne);
               check_field("integrator_reset", due_status.integrator_reset,
                           rsp_integrator_reset);
               check_field("head_free_request", due_status.head_free_request,
                           rsp_head_free_request);
               check_field("throttle_out", due_status.throttle_out, rsp_throttle_out);
               check_field("takeoff_altitude", due_status.takeoff_altitude,
                           rsp_takeoff_altitude);
            end
         end
         if (req_valid && req_ready) begin
            status_backlog.push_back(supervise_tick(req_now_ms, req_last_radio_ms,
                                                    req_pitch_tenths, req_roll_tenths,
                                                    req_throttle_in, req_altitude_z,
                                                    req_arm_command));
         end
         status_backlog_size <= status_backlog.size();
      end
   end

endmodule

[tb/tb_flight_failsafe_supervisor_unit.sv]
// Testbench top of the flight failsafe supervisor: clock, reset, stimulus phases and verdict.
module tb_flight_failsafe_supervisor_unit;
   import ffs_pkg::*;

   // The package names only the three live arm commands; the fourth code is reserved.
   localparam logic [1:0] ARM_CMD_RESERVED = 2'd3;
   // Hard ceiling on the run. The slowest legal run stays far below this.
   localparam int CYCLE_LIMIT = 400000;
   // Length of the single long receiver hold-off.
   localparam int LONG_HOLD_CYCLES = 300;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [31:0]            req_now_ms = '0;
   logic [31:0]            req_last_radio_ms = '0;
   logic signed [11:0]     req_pitch_tenths = '0;
   logic signed [11:0]     req_roll_tenths = '0;
   logic [9:0]             req_throttle_in = '0;
   logic signed [31:0]     req_altitude_z = '0;
   logic [1:0]             req_arm_command = ARM_CMD_NONE;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_flight_mode;
   logic                   rsp_motors_armed;
   logic                   rsp_motor_kill;
   logic                   rsp_radio_lost;
   logic                   rsp_airborne;
   logic                   rsp_integrator_reset;
   logic                   rsp_head_free_request;
   logic [9:0]             rsp_throttle_out;
   logic signed [31:0]     rsp_takeoff_altitude;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int                     results_due;
   int                     mismatch_total;

   // Idle shaping. The sender side is only touched by the main process; the receiver
   // percentage is handed over with a nonblocking write.
   int                     send_idle_pct = 0;
   int                     recv_stall_pct = 0;
   logic                   hold_arm = 1'b0;
   bit                     hold_taken = 1'b0;
   int                     hold_left = 0;
   int                     cycle_count = 0;

   // Local copy of the register settings, so that the random ticks can aim at the limits.
   logic [10:0]            cfg_tilt = TILT_LIMIT_RST;
   logic [15:0]            cfg_rc = RC_TIMEOUT_MS_RST;
   logic [15:0]            cfg_land = LAND_TIME_MS_RST;
   logic [9:0]             cfg_takeoff = TAKEOFF_THROTTLE_RST;
   logic [9:0]             cfg_standby = STANDBY_THROTTLE_RST;

   // Flight scenario state: a running millisecond clock, radio outages that last a few
   // ticks, and a pilot who holds the stick high or low for a while.
   logic [31:0]            flight_clock_ms = '0;
   int                     link_down_ticks = 0;
   bit                     throttle_up = 1'b0;

   flight_failsafe_supervisor_unit i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_now_ms            (req_now_ms),
      .req_last_radio_ms     (req_last_radio_ms),
      .req_pitch_tenths      (req_pitch_tenths),
      .req_roll_tenths       (req_roll_tenths),
      .req_throttle_in       (req_throttle_in),
      .req_altitude_z        (req_altitude_z),
      .req_arm_command       (req_arm_command),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_flight_mode       (rsp_flight_mode),
      .rsp_motors_armed      (rsp_motors_armed),
      .rsp_motor_kill        (rsp_motor_kill),
      .rsp_radio_lost        (rsp_radio_lost),
      .rsp_airborne          (rsp_airborne),
      .rsp_integrator_reset  (rsp_integrator_reset),
      .rsp_head_free_request (rsp_head_free_request),
      .rsp_throttle_out      (rsp_throttle_out),
      .rsp_takeoff_altitude  (rsp_takeoff_altitude),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // The checker watches the same wires as the block and counts every mismatch.
   flight_failsafe_supervisor_checker i_checker (
      .*,
      .status_backlog_size (results_due),
      .mismatch_count      (mismatch_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog. A hung handshake ends the run here as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_flight_failsafe_supervisor_unit: done, errors");
         $finish;
      end
   end

   // Receiver. It stalls at the current percentage, except once, when the main process
   // asks for a long hold-off; that stretch is counted here so the sender can keep
   // pushing beats into the block until its input stalls.
   always @(posedge clock) begin
      if (hold_arm && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one request beat and wait for it to be taken. Valid is only lowered when
   // an idle cycle is actually inserted, so a back-to-back beat keeps it high without
   // a second assignment in the same step.
   task automatic send_tick(input logic [31:0] now, input logic [31:0] last,
                            input logic [11:0] pitch, input logic [11:0] roll,
                            input logic [9:0] thr, input logic [31:0] alt,
                            input logic [1:0] cmd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_now_ms        <= now;
      req_last_radio_ms <= last;
      req_pitch_tenths  <= pitch;
      req_roll_tenths   <= roll;
      req_throttle_in   <= thr;
      req_altitude_z    <= alt;
      req_arm_command   <= cmd;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait until every response beat has been seen, then let the block
   // settle before anything else touches it.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (4) @(posedge clock);
   endtask

   // One register write beat. Valid stays high for a following write and is dropped
   // by the caller after the last one.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write all five registers, then poke the unused indexes, which must be ignored.
   task automatic program_settings(input logic [15:0] tilt, input logic [15:0] rc,
                                   input logic [15:0] land, input logic [15:0] takeoff,
                                   input logic [15:0] standby);
      csr_write(CSR_TILT_LIMIT, tilt);
      csr_write(CSR_RC_TIMEOUT_MS, rc);
      csr_write(CSR_LAND_TIME_MS, land);
      csr_write(CSR_TAKEOFF_THROTTLE, takeoff);
      csr_write(CSR_STANDBY_THROTTLE, standby);
      for (int k = CSR_STANDBY_THROTTLE + 1; k < (1 << CSR_INDEX_W); k++) begin
         csr_write(k[CSR_INDEX_W-1:0], CSR_DATA_W'($urandom()));
      end
      csr_valid <= 1'b0;
      cfg_tilt    = tilt[10:0];
      cfg_rc      = rc;
      cfg_land    = land;
      cfg_takeoff = takeoff[9:0];
      cfg_standby = standby[9:0];
      @(posedge clock);
   endtask

   // Attitude sample: mostly well inside the limit, sometimes right at it, and now and
   // then any 12-bit code, the most negative one included.
   function automatic logic [11:0] tilt_sample();
      logic [11:0] mag;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 4) begin
         return 12'($urandom());
      end else if (pick < 10) begin
         mag = 12'(cfg_tilt) + 12'($urandom_range(0, 1));
      end else begin
         mag = 12'($urandom_range(0, cfg_tilt / 2));
      end
      return $urandom_range(1) ? -mag : mag;
   endfunction

   // One random control tick shaped like real flight: time moves forward in small
   // steps, the pilot arms and takes off, the link drops for a while so that the
   // landing sequencer runs, and occasional noise jumps anywhere in the field ranges.
   task automatic offer_flight_tick();
      logic [31:0] now;
      logic [31:0] last;
      logic [31:0] alt;
      logic [11:0] pitch;
      logic [11:0] roll;
      logic [9:0]  thr;
      logic [1:0]  cmd;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 3) begin
         flight_clock_ms = $urandom();
      end else begin
         flight_clock_ms = flight_clock_ms + 32'($urandom_range(0, 400));
      end
      now = flight_clock_ms;

      if (link_down_ticks > 0) begin
         link_down_ticks--;
      end else if ($urandom_range(99) < 6) begin
         link_down_ticks = $urandom_range(1, 12);
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
         last = $urandom();
      end else if (pick < 10) begin
         // Silence one below, at, or one above the timeout.
         last = now - ({16'd0, cfg_rc} + 32'($urandom_range(0, 2)) - 32'd1);
      end else if (link_down_ticks > 0) begin
         last = now - ({16'd0, cfg_rc} + 32'($urandom_range(1, 3000)));
      end else if (pick < 15) begin
         last = now;
      end else begin
         last = now - 32'($urandom_range(0, cfg_rc));
      end

      pitch = tilt_sample();
      roll  = tilt_sample();

      if ($urandom_range(99) < 10) begin
         throttle_up = !throttle_up;
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
         thr = 10'($urandom());
      end else if (pick < 16) begin
         thr = cfg_takeoff + 10'($urandom_range(0, 2)) - 10'd1;
      end else if (throttle_up) begin
         thr = 10'($urandom_range(cfg_takeoff, 1023));
      end else begin
         thr = (cfg_takeoff == 0) ? 10'd0 : 10'($urandom_range(0, cfg_takeoff - 1));
      end

      alt = ($urandom_range(99) < 5) ? 32'h8000_0000 : $urandom();

      pick = $urandom_range(99);
      if (pick < 12) begin
         cmd = ARM_CMD_ARM;
      end else if (pick < 17) begin
         cmd = ARM_CMD_DISARM;
      end else if (pick < 20) begin
         cmd = ARM_CMD_RESERVED;
      end else begin
         cmd = ARM_CMD_NONE;
      end

      send_tick(now, last, pitch, roll, thr, alt, cmd);
   endtask

   // One phase: drain, reprogram, set the idle pattern, then run random ticks.
   task automatic run_phase(input int send_pct, input int stall_pct,
                            input logic [15:0] tilt, input logic [15:0] rc,
                            input logic [15:0] land, input logic [15:0] takeoff,
                            input logic [15:0] standby, input int items,
                            input logic [31:0] start_ms, input bit long_hold);
      wait_for_results();
      program_settings(tilt, rc, land, takeoff, standby);
      send_idle_pct = send_pct;
      recv_stall_pct <= stall_pct;
      flight_clock_ms = start_ms;
      if (long_hold) begin
         hold_arm <= 1'b1;
      end
      repeat (items) offer_flight_tick();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed ticks with the reset settings: tilt 80 deg, timeout 1 s, land 4 s,
      // takeoff at 600 and standby at 200.
      // Quiet tick with equal time stamps, then the reserved arm code.
      send_tick(32'd0, 32'd0, 12'd0, 12'd0, 10'd0, 32'd0, ARM_CMD_NONE);
      send_tick(32'd10, 32'd10, 12'd0, 12'd0, 10'd0, 32'd0, ARM_CMD_RESERVED);
      // Armed on the ground with low stick: standby throttle.
      send_tick(32'd20, 32'd20, 12'd0, 12'd0, 10'd0, 32'd0, ARM_CMD_ARM);
      // Takeoff at the most negative altitude: its negation wraps onto itself.
      send_tick(32'd30, 32'd30, 12'd0, 12'd0, 10'd1023, 32'h8000_0000, ARM_CMD_NONE);
      // Most negative pitch code kills the motors; so does roll past the limit.
      send_tick(32'd40, 32'd40, 12'h800, 12'd0, 10'd1023, 32'd0, ARM_CMD_NONE);
      send_tick(32'd50, 32'd50, 12'd0, 12'd1800, 10'd0, 32'd0, ARM_CMD_ARM);
      // Tilt exactly at the limit is still fine.
      send_tick(32'd60, 32'd60, 12'd800, -12'sd800, 10'd0, 32'd0, ARM_CMD_ARM);
      // Link lost while airborne: landing starts and the timer latches, then runs out
      // one millisecond after the land time.
      send_tick(32'd5000, 32'd3999, 12'd0, 12'd0, 10'd0, 32'd7, ARM_CMD_NONE);
      send_tick(32'd9000, 32'd9000, 12'd0, 12'd0, 10'd0, 32'd0, ARM_CMD_NONE);
      send_tick(32'd9001, 32'd9001, 12'd0, 12'd0, 10'd0, 32'd0, ARM_CMD_NONE);
      // New takeoff, then lost link with the stick high: landing turns back into
      // climb rate within the same tick.
      send_tick(32'd9100, 32'd9100, 12'd0, 12'd0, 10'd700, -32'sd12345, ARM_CMD_ARM);
      send_tick(32'd12000, 32'd10000, 12'd0, 12'd0, 10'd1023, 32'd100, ARM_CMD_NONE);
      // Landing with the timer latched, abandoned by a climb, then resumed with the
      // stale start, which has long run out.
      send_tick(32'd12100, 32'd10000, 12'd0, 12'd0, 10'd0, 32'd0, ARM_CMD_NONE);
      send_tick(32'd12200, 32'd12200, 12'd0, 12'd0, 10'd900, 32'd55, ARM_CMD_NONE);
      send_tick(32'd30000, 32'd20000, 12'd0, 12'd0, 10'd0, 32'd0, ARM_CMD_NONE);
      // Lost link on the ground and disarmed: flag only. Armed on the ground: landing
      // ends at once and disarms.
      send_tick(32'd30100, 32'd20000, 12'd0, 12'd0, 10'd0, 32'd0, ARM_CMD_DISARM);
      send_tick(32'd30200, 32'd20000, 12'd0, 12'd0, 10'd0, 32'd0, ARM_CMD_ARM);
      // Silence taken modulo 65536 across wrapping time stamps.
      send_tick(32'h0001_0005, 32'hFFFF_FFF0, 12'd0, 12'd0, 10'd0, 32'd0, ARM_CMD_NONE);
      send_tick(32'd0, 32'h0000_FFFF, 12'd0, 12'd0, 10'd0, 32'd0, ARM_CMD_NONE);
      // Extreme codes in every field.
      send_tick(32'hFFFF_FFFF, 32'd0, 12'h7FF, 12'hFFF, 10'd1023, 32'h7FFF_FFFF,
                ARM_CMD_DISARM);
      // Throttle one below, then exactly at, the takeoff threshold.
      send_tick(32'd100, 32'd100, 12'd0, 12'd0, 10'd599, 32'd0, ARM_CMD_ARM);
      send_tick(32'd200, 32'd200, 12'd0, 12'd0, 10'd600, -32'sd1, ARM_CMD_NONE);

      // Random phases over the idle patterns and a spread of settings, extremes included.
      // Back to back with the reset values written explicitly.
      run_phase(0, 0, 16'd800, 16'd1000, 16'd4000, 16'd600, 16'd200, 250, 32'd0, 1'b0);
      // Sender idles about half the cycles.
      run_phase(51, 0, 16'd1800, 16'd300, 16'd600, 16'd400, 16'd100, 250,
                32'd100000, 1'b0);
      // Receiver stalls about half the cycles; zero timeout, zero land time, takeoff at 0.
      run_phase(0, 51, 16'd300, 16'd0, 16'd0, 16'd0, 16'd1023, 150, 32'd2000000, 1'b0);
      // Both idle lightly; zero tilt limit, longest timeouts, takeoff at full stick.
      run_phase(16, 16, 16'd0, 16'd65535, 16'd65535, 16'd1023, 16'd0, 100,
                32'd7000000, 1'b0);
      // All ones written, so every register is masked to its width. The receiver holds
      // off for a long stretch while the sender keeps offering beats.
      run_phase(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 100,
                32'd9000000, 1'b1);
      // Both idle about half the cycles with mid-range settings.
      run_phase(51, 51, 16'd900, 16'd1500, 16'd2000, 16'd512, 16'd300, 380,
                32'd40000000, 1'b0);
      // Light idling with the flight clock just below its wrap.
      run_phase(16, 16, 16'd1200, 16'd800, 16'd200, 16'd700, 16'd50, 100,
                32'hFFFF_F000, 1'b0);

      wait_for_results();
      if (mismatch_total == 0) begin
         $display("tb_flight_failsafe_supervisor_unit: done, clean");
      end else begin
         $display("tb_flight_failsafe_supervisor_unit: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
hdl/ffs_pkg.sv
hdl/flight_failsafe_supervisor_unit.sv
hdl/ffs_checker.sv
tb/flight_failsafe_supervisor_checker.sv
tb/tb_flight_failsafe_supervisor_unit.sv
